>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the complex arithmetic unit.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Flag a condition that must never be true.
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

>>> hw/rtl/cau_pkg.sv
// Types, opcodes and arithmetic helpers of the complex arithmetic unit.
// Used by the request and response interfaces and by the top level.
package cau_pkg;

	localparam int DATA_WIDTH   = 16;
	localparam int FRAC_BITS    = 8;
	localparam int CMD_W        = 3;

	// Full product and exact sum of two products
	localparam int PROD_W       = 2 * DATA_WIDTH;
	localparam int WIDE_W       = PROD_W + 1;

	// Square root: one result bit per iteration, two iterations per stage
	localparam int RT_ITERS     = DATA_WIDTH;
	localparam int RT_PER_STAGE = 2;
	localparam int RT_STAGES    = (RT_ITERS + RT_PER_STAGE - 1) / RT_PER_STAGE;

	typedef logic [CMD_W-1:0]         cmd_t;
	typedef logic signed [DATA_WIDTH-1:0] sample_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	localparam cmd_t OP_ADD    = CMD_W'(0);
	localparam cmd_t OP_SUB    = CMD_W'(1);
	localparam cmd_t OP_MUL_RE = CMD_W'(2);
	localparam cmd_t OP_MUL_IM = CMD_W'(3);
	localparam cmd_t OP_CMUL   = CMD_W'(4);
	localparam cmd_t OP_MAG    = CMD_W'(5);

	localparam sample_t SAMPLE_MAX = sample_t'((longint'(1) << (DATA_WIDTH - 1)) - 1);
	localparam sample_t SAMPLE_MIN = ~SAMPLE_MAX;
	localparam wide_t   WIDE_MAX   = wide_t'(SAMPLE_MAX);
	localparam wide_t   WIDE_MIN   = wide_t'(SAMPLE_MIN);

	typedef struct packed {
		logic [PROD_W-1:0] x;
		logic [WIDE_W-1:0] res;
	} rt_t;

	typedef struct packed {
		logic    hit;
		sample_t val;
	} sat_t;

	// One iteration of the bitwise square root; idx 0 handles the top bit pair.
	function automatic rt_t rt_step(rt_t s, int idx);
		logic [WIDE_W-1:0] bitv;
		logic [WIDE_W-1:0] trial;
		rt_t               n;
		bitv  = WIDE_W'(1) << (2 * (RT_ITERS - 1 - idx));
		trial = s.res + bitv;
		n     = s;
		if ({1'b0, s.x} >= trial) begin
			n.x   = s.x - trial[PROD_W-1:0];
			n.res = (s.res >> 1) + bitv;
		end else begin
			n.res = s.res >> 1;
		end
		return n;
	endfunction

	// Clamp to the sample range and report whether clamping happened.
	function automatic sat_t saturate(wide_t v);
		sat_t r;
		r.hit = 1'b0;
		r.val = v[DATA_WIDTH-1:0];
		if (v > WIDE_MAX) begin
			r.hit = 1'b1;
			r.val = SAMPLE_MAX;
		end else if (v < WIDE_MIN) begin
			r.hit = 1'b1;
			r.val = SAMPLE_MIN;
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/cau_req_if.sv
// Request channel of the complex arithmetic unit: opcode and operands A, B.
// Depends on cau_pkg for the payload types.
interface cau_req_if
	import cau_pkg::*;
();
	logic    valid;
	logic    ready;
	cmd_t    cmd;
	sample_t a_re;
	sample_t a_im;
	sample_t b_re;
	sample_t b_im;

	modport source (output valid, cmd, a_re, a_im, b_re, b_im, input ready);
	modport sink   (input valid, cmd, a_re, a_im, b_re, b_im, output ready);
endinterface

>>> hw/rtl/cau_rsp_if.sv
// Response channel of the complex arithmetic unit: result parts and overflow.
// Depends on cau_pkg for the payload types.
interface cau_rsp_if
	import cau_pkg::*;
();
	logic    valid;
	logic    ready;
	sample_t res_re;
	sample_t res_im;
	logic    overflow;

	modport source (output valid, res_re, res_im, overflow, input ready);
	modport sink   (input valid, res_re, res_im, overflow, output ready);
endinterface

>>> hw/rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit in signed fixed point; needs cau_pkg, cau_req_if, cau_rsp_if.
// Pipeline: stage 1, stage 2, the eight two-bit square root stages and the output
// register. Throughput: one request per cycle while rsp is ready;
// each stage stalls only when it is full and blocked.
// Reset: arst_n clears every valid bit at once; data registers are not reset.
`include "assert_macros.svh"

module complex_arithmetic_unit
	import cau_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	cau_req_if.sink   req,
	cau_rsp_if.source rsp
);

	// ------------------------------------------------------------------
	// Stage enables: a stage loads when it is empty or its successor
	// loads in the same cycle, so bubbles collapse and nothing is lost.
	// ------------------------------------------------------------------
	logic en_s1, en_s2, out_en;
	logic rt_en [RT_STAGES];

	// ------------------------------------------------------------------
	// Stage 1: four signed multipliers. For a magnitude request the first
	// two square the real and imaginary parts of A instead.
	// ------------------------------------------------------------------
	logic    vld_s1, mag_s1;
	cmd_t    cmd_s1;
	sample_t ar_s1, ai_s1, br_s1, bi_s1;
	prod_t   p0_s1, p1_s1, p2_s1, p3_s1;

	logic    is_mag;
	sample_t mul0_b, mul1_b;

	assign is_mag = (req.cmd == OP_MAG);
	assign mul0_b = is_mag ? req.a_re : req.b_re;
	assign mul1_b = is_mag ? req.a_im : req.b_im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && req.valid) begin
			cmd_s1 <= req.cmd;
			mag_s1 <= is_mag;
			ar_s1  <= req.a_re;
			ai_s1  <= req.a_im;
			br_s1  <= req.b_re;
			bi_s1  <= req.b_im;
			p0_s1  <= prod_t'(req.a_re) * prod_t'(mul0_b);   // ar*br or ar*ar
			p1_s1  <= prod_t'(req.a_im) * prod_t'(mul1_b);   // ai*bi or ai*ai
			p2_s1  <= prod_t'(req.a_re) * prod_t'(req.b_im); // ar*bi
			p3_s1  <= prod_t'(req.a_im) * prod_t'(req.b_re); // ai*br
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: exact sums, then drop the fraction bits with an arithmetic
	// shift (floor). Build the sum of squares for the magnitude path.
	// ------------------------------------------------------------------
	logic              vld_s2, mag_s2;
	wide_t             re_s2, im_s2;
	logic [PROD_W-1:0] sq_s2;

	wide_t             re_c, im_c;
	logic [PROD_W-1:0] sq_c;

	always_comb begin
		re_c = '0;
		im_c = '0;
		case (cmd_s1)
			OP_ADD: begin
				re_c = wide_t'(ar_s1) + wide_t'(br_s1);
				im_c = wide_t'(ai_s1) + wide_t'(bi_s1);
			end
			OP_SUB: begin
				re_c = wide_t'(ar_s1) - wide_t'(br_s1);
				im_c = wide_t'(ai_s1) - wide_t'(bi_s1);
			end
			OP_MUL_RE: begin
				re_c = wide_t'(p0_s1) >>> FRAC_BITS;
				im_c = wide_t'(p3_s1) >>> FRAC_BITS;
			end
			OP_MUL_IM: begin
				// times i*s: real part takes the negated imaginary product
				re_c = (-wide_t'(p3_s1)) >>> FRAC_BITS;
				im_c = wide_t'(p0_s1) >>> FRAC_BITS;
			end
			OP_CMUL: begin
				re_c = (wide_t'(p0_s1) - wide_t'(p1_s1)) >>> FRAC_BITS;
				im_c = (wide_t'(p2_s1) + wide_t'(p3_s1)) >>> FRAC_BITS;
			end
			default: begin
				// magnitude fills its real part later; unused codes give zero
				re_c = '0;
				im_c = '0;
			end
		endcase
	end

	// both squares are non-negative, so their sum fits unsigned in PROD_W bits
	assign sq_c = $unsigned(p0_s1) + $unsigned(p1_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			mag_s2 <= mag_s1;
			re_s2  <= re_c;
			im_s2  <= im_c;
			sq_s2  <= sq_c;
		end
	end

	// ------------------------------------------------------------------
	// Square root stages: each runs RT_PER_STAGE bit iterations of the
	// restoring integer root. The floor root of the 2F-fraction sum is
	// already in F-fraction form. Other results ride along untouched.
	// ------------------------------------------------------------------
	logic  rt_vld_s [RT_STAGES];
	logic  rt_mag_s [RT_STAGES];
	wide_t rt_re_s  [RT_STAGES];
	wide_t rt_im_s  [RT_STAGES];
	rt_t   rt_s     [RT_STAGES];

	logic  rt_in_vld [RT_STAGES];
	logic  rt_in_mag [RT_STAGES];
	wide_t rt_in_re  [RT_STAGES];
	wide_t rt_in_im  [RT_STAGES];
	rt_t   rt_in     [RT_STAGES];

	for (genvar k = 0; k < RT_STAGES; k++) begin : g_rt
		rt_t rt_nxt;

		if (k == 0) begin : g_first
			assign rt_in_vld[k] = vld_s2;
			assign rt_in_mag[k] = mag_s2;
			assign rt_in_re[k]  = re_s2;
			assign rt_in_im[k]  = im_s2;
			assign rt_in[k]     = '{x: sq_s2, res: '0};
		end else begin : g_next
			assign rt_in_vld[k] = rt_vld_s[k-1];
			assign rt_in_mag[k] = rt_mag_s[k-1];
			assign rt_in_re[k]  = rt_re_s[k-1];
			assign rt_in_im[k]  = rt_im_s[k-1];
			assign rt_in[k]     = rt_s[k-1];
		end

		if (k == RT_STAGES - 1) begin : g_en_last
			assign rt_en[k] = !rt_vld_s[k] || out_en;
		end else begin : g_en_mid
			assign rt_en[k] = !rt_vld_s[k] || rt_en[k+1];
		end

		always_comb begin
			rt_nxt = rt_in[k];
			for (int j = 0; j < RT_PER_STAGE; j++) begin
				if (k * RT_PER_STAGE + j < RT_ITERS) begin
					rt_nxt = rt_step(rt_nxt, k * RT_PER_STAGE + j);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[k] <= 1'b0;
			end else if (rt_en[k]) begin
				rt_vld_s[k] <= rt_in_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rt_en[k] && rt_in_vld[k]) begin
				rt_mag_s[k] <= rt_in_mag[k];
				rt_re_s[k]  <= rt_in_re[k];
				rt_im_s[k]  <= rt_in_im[k];
				rt_s[k]     <= rt_nxt;
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register: pick the root for magnitude requests, saturate
	// both parts and merge the clamp flags. It holds while rsp stalls.
	// ------------------------------------------------------------------
	localparam int LAST = RT_STAGES - 1;

	logic    out_vld_q, out_mag_q, out_ovf_q;
	sample_t out_re_q, out_im_q;

	wide_t re_pick;
	sat_t  sat_re, sat_im;

	// the root is below 2^DATA_WIDTH, so its top bit is clear
	assign re_pick = rt_mag_s[LAST] ? $signed(rt_s[LAST].res) : rt_re_s[LAST];
	assign sat_re  = saturate(re_pick);
	assign sat_im  = saturate(rt_im_s[LAST]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_en) begin
			out_vld_q <= rt_vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && rt_vld_s[LAST]) begin
			out_mag_q <= rt_mag_s[LAST];
			out_re_q  <= sat_re.val;
			out_im_q  <= sat_im.val;
			out_ovf_q <= sat_re.hit | sat_im.hit;
		end
	end

	// ------------------------------------------------------------------
	// Handshake: the ready chain runs back from the response side.
	// ------------------------------------------------------------------
	assign out_en    = !out_vld_q || rsp.ready;
	assign en_s2     = !vld_s2 || rt_en[0];
	assign en_s1     = !vld_s1 || en_s2;
	assign req.ready = en_s1;

	assign rsp.valid    = out_vld_q;
	assign rsp.res_re   = out_re_q;
	assign rsp.res_im   = out_im_q;
	assign rsp.overflow = out_ovf_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	logic out_clamped;

	// a part sitting at either range limit is what a clamp leaves behind
	assign out_clamped = out_re_q == SAMPLE_MAX || out_re_q == SAMPLE_MIN ||
		out_im_q == SAMPLE_MAX || out_im_q == SAMPLE_MIN;

	`ASSERT_CLK(a_req_enters_s1, req.valid && req.ready |=> vld_s1, "request lost at stage 1")
	`ASSERT_CLK(a_s2_holds, vld_s2 && !en_s2 |=> vld_s2, "stalled stage 2 dropped its request")
	`ASSERT_CLK(a_mag_im_zero, out_vld_q && out_mag_q |-> out_im_q == '0, "magnitude im not zero")
	`ASSERT_NEVER(a_ovf_extreme, out_vld_q && out_ovf_q && !out_clamped, "overflow without clamp")

endmodule

>>> sim/cau_result_check.sv
`timescale 1ns / 100ps
// Result checker for the complex arithmetic unit: watches both channels and predicts every result.
// Depends on cau_pkg, cau_req_if and cau_rsp_if. Reports its mismatch count and open predictions.
module cau_result_check
	import cau_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	cau_req_if   req,
	cau_rsp_if   rsp,
	output int   mismatch_count,
	output int   open_count
);

	typedef struct packed {
		sample_t re;
		sample_t im;
		logic    ovf;
	} cplx_result_t;

	cplx_result_t pending_results[$];

	// Largest root whose square does not exceed x; x stays below 2^32 here.
	function automatic longint floor_sqrt(longint x);
		longint root;
		longint trial;
		root = 0;
		for (int b = 16; b >= 0; b--) begin
			trial = root | (longint'(1) << b);
			if (trial * trial <= x)
				root = trial;
		end
		return root;
	endfunction

	function automatic sample_t clamp_part(longint v, inout logic hit);
		if (v > longint'(SAMPLE_MAX)) begin
			hit = 1'b1;
			return SAMPLE_MAX;
		end
		if (v < longint'(SAMPLE_MIN)) begin
			hit = 1'b1;
			return SAMPLE_MIN;
		end
		return sample_t'(v);
	endfunction

	// Exact products and sums, floor by arithmetic shift, clamp each part.
	function automatic cplx_result_t cplx_op_result(input cmd_t op,
			input sample_t ar, ai, br, bi);
		longint       re;
		longint       im;
		logic         hit;
		cplx_result_t r;
		re  = 0;
		im  = 0;
		hit = 1'b0;
		case (op)
			OP_ADD: begin
				re = longint'(ar) + longint'(br);
				im = longint'(ai) + longint'(bi);
			end
			OP_SUB: begin
				re = longint'(ar) - longint'(br);
				im = longint'(ai) - longint'(bi);
			end
			OP_MUL_RE: begin
				re = (longint'(ar) * longint'(br)) >>> FRAC_BITS;
				im = (longint'(ai) * longint'(br)) >>> FRAC_BITS;
			end
			OP_MUL_IM: begin
				re = (-(longint'(ai) * longint'(br))) >>> FRAC_BITS;
				im = (longint'(ar) * longint'(br)) >>> FRAC_BITS;
			end
			OP_CMUL: begin
				re = (longint'(ar) * longint'(br) - longint'(ai) * longint'(bi)) >>> FRAC_BITS;
				im = (longint'(ar) * longint'(bi) + longint'(ai) * longint'(br)) >>> FRAC_BITS;
			end
			OP_MAG: begin
				re = floor_sqrt(longint'(ar) * longint'(ar) + longint'(ai) * longint'(ai));
				im = 0;
			end
			default: begin
				re = 0;
				im = 0;
			end
		endcase
		r.re  = clamp_part(re, hit);
		r.im  = clamp_part(im, hit);
		r.ovf = hit;
		return r;
	endfunction

	task automatic flag_field(string field, longint want, longint got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		cplx_result_t want;
		if (!arst_n) begin
			pending_results.delete();
			mismatch_count = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual re %0d im %0d ovf %0b",
						$time, rsp.res_re, rsp.res_im, rsp.overflow);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					if (rsp.res_re !== want.re)
						flag_field("res_re", want.re, rsp.res_re);
					if (rsp.res_im !== want.im)
						flag_field("res_im", want.im, rsp.res_im);
					if (rsp.overflow !== want.ovf)
						flag_field("overflow", want.ovf, rsp.overflow);
				end
			end
			if (req.valid && req.ready)
				pending_results.push_back(cplx_op_result(req.cmd, req.a_re, req.a_im,
					req.b_re, req.b_im));
		end
		open_count = pending_results.size();
	end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Top of the complex arithmetic unit testbench: clock, reset, request stimulus and verdict.
// Depends on cau_pkg, the two channel interfaces, the unit itself and cau_result_check.
module testbench;
	import cau_pkg::*;

	// Opcodes the unit does not define; they must give a zero result.
	localparam cmd_t OP_SPARE_LO = CMD_W'(6);
	localparam cmd_t OP_SPARE_HI = CMD_W'(7);

	// Handy fixed-point values
	localparam sample_t ONE_FX = sample_t'(1 << FRAC_BITS);
	localparam sample_t LSB_FX = sample_t'(1);

	localparam int ITEM_TARGET = 500;
	localparam int TAIL_CYCLES = 24;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   open_count;
	int   sent_count;

	cau_req_if req ();
	cau_rsp_if rsp ();

	complex_arithmetic_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	cau_result_check result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.rsp            (rsp),
		.mismatch_count (mismatch_count),
		.open_count     (open_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: the slowest legal run needs well under a tenth of this.
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	// Mix full-range noise, small values around zero and the corner values.
	function automatic sample_t pick_operand();
		int unsigned sel;
		int          v;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return sample_t'($urandom);
		if (sel < 8) begin
			v = int'($urandom_range(0, 8 * ONE_FX)) - 4 * ONE_FX;
			return sample_t'(v);
		end
		case ($urandom_range(0, 5))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return sample_t'(0);
			3: return -LSB_FX;
			4: return ONE_FX;
			default: return -ONE_FX;
		endcase
	endfunction

	// Present one request and hold it until the unit takes it. Enter and leave on a
	// falling edge so valid can stay high across back-to-back requests.
	task automatic send_request(input cmd_t op, input sample_t ar, ai, br, bi);
		req.valid <= 1'b1;
		req.cmd   <= op;
		req.a_re  <= ar;
		req.a_im  <= ai;
		req.b_re  <= br;
		req.b_im  <= bi;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
		sent_count++;
	endtask

	task automatic send_random_request();
		cmd_t op;
		if ($urandom_range(0, 19) == 0)
			op = cmd_t'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		else
			op = cmd_t'($urandom_range(OP_ADD, OP_MAG));
		send_request(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
	endtask

	// Drop valid for a gap and wiggle the payload so nothing leaks through while idle.
	task automatic hold_off(int unsigned cycles);
		if (cycles == 0)
			return;
		req.valid <= 1'b0;
		repeat (cycles) begin
			req.cmd  <= cmd_t'($urandom);
			req.a_re <= sample_t'($urandom);
			req.a_im <= sample_t'($urandom);
			req.b_re <= sample_t'($urandom);
			req.b_im <= sample_t'($urandom);
			@(negedge clk);
		end
	endtask

	// Pause the sender until every result in flight has come back.
	task automatic wait_drained();
		req.valid <= 1'b0;
		do
			@(negedge clk);
		while (open_count != 0);
	endtask

	// Receiver: stall in stretches, each with a pattern of its own.
	initial begin
		int unsigned mode;
		int unsigned stretch;
		int unsigned period;
		rsp.ready = 1'b0;
		wait (arst_n);
		forever begin
			mode    = $urandom_range(0, 4);
			stretch = $urandom_range(16, 96);
			period  = $urandom_range(2, 7);
			for (int unsigned n = 0; n < stretch; n++) begin
				@(negedge clk);
				case (mode)
					0: rsp.ready <= 1'b1;
					1: rsp.ready <= 1'($urandom_range(0, 1));
					2: rsp.ready <= ($urandom_range(0, 3) == 0);
					3: rsp.ready <= ((n % period) != 0);
					default: rsp.ready <= 1'b0;
				endcase
			end
		end
	end

	initial begin
		bit paused;
		int unsigned burst;
		sent_count = 0;
		paused     = 1'b0;
		arst_n     = 1'b0;
		req.valid  = 1'b0;
		req.cmd    = OP_ADD;
		req.a_re   = '0;
		req.a_im   = '0;
		req.b_re   = '0;
		req.b_im   = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: saturation on every path, truncation toward minus infinity,
		// ignored operands, and the opcodes with no meaning.
		send_request(OP_ADD, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
		send_request(OP_ADD, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
		send_request(OP_ADD, '0, '0, '0, '0);
		send_request(OP_SUB, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN);
		send_request(OP_SUB, ONE_FX, -ONE_FX, ONE_FX, ONE_FX);
		send_request(OP_MUL_RE, SAMPLE_MIN, SAMPLE_MAX, -ONE_FX, SAMPLE_MAX);
		send_request(OP_MUL_RE, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, '0);
		send_request(OP_MUL_RE, -LSB_FX, LSB_FX, LSB_FX, SAMPLE_MIN);
		send_request(OP_MUL_RE, ONE_FX, -ONE_FX, '0, SAMPLE_MAX);
		send_request(OP_MUL_IM, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
		send_request(OP_MUL_IM, ONE_FX, ONE_FX, ONE_FX, SAMPLE_MAX);
		send_request(OP_MUL_IM, -LSB_FX, LSB_FX, LSB_FX, '0);
		send_request(OP_CMUL, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
		send_request(OP_CMUL, ONE_FX, '0, ONE_FX, '0);
		send_request(OP_CMUL, '0, ONE_FX, '0, ONE_FX);
		send_request(OP_CMUL, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX);
		send_request(OP_CMUL, -LSB_FX, '0, LSB_FX, '0);
		send_request(OP_MAG, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
		send_request(OP_MAG, sample_t'(3 * ONE_FX), sample_t'(4 * ONE_FX), '0, '0);
		send_request(OP_MAG, '0, '0, SAMPLE_MAX, SAMPLE_MAX);
		send_request(OP_MAG, -LSB_FX, '0, '0, '0);
		send_request(OP_MAG, SAMPLE_MAX, '0, '0, '0);
		send_request(OP_SPARE_LO, pick_operand(), pick_operand(), pick_operand(),
			pick_operand());
		send_request(OP_SPARE_HI, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);

		// Let the directed requests drain before the random traffic starts.
		wait_drained();

		// Random: bursts of back-to-back requests separated by gaps, with one
		// full drain halfway through.
		while (sent_count < ITEM_TARGET) begin
			if (!paused && sent_count >= ITEM_TARGET / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			burst = $urandom_range(1, 24);
			repeat (burst)
				send_random_request();
			if ($urandom_range(0, 3) != 0)
				hold_off($urandom_range(1, 8));
		end

		// Drop valid, collect the tail, then give the unit time to show any stray result.
		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> complex_arithmetic_unit.f
+incdir+hw/rtl
hw/rtl/cau_pkg.sv
hw/rtl/cau_req_if.sv
hw/rtl/cau_rsp_if.sv
hw/rtl/complex_arithmetic_unit.sv
sim/cau_result_check.sv
sim/testbench.sv
